// ----- hdl/monotone_valley_detector_assert.svh -----
// Assertion macros shared by the valley detector RTL.
// Depends on i_clk and i_rst_n being visible in the including module.
`ifndef MONOTONE_VALLEY_DETECTOR_ASSERT_SVH
`define MONOTONE_VALLEY_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("valley detector check failed");
// Next-cycle implication, checked out of reset.
`define MVD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("valley detector check failed");
`else
`define MVD_ASSERT_IMP(label, ante, cons)
`define MVD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hdl/mvd_pkg.sv -----
// Types and fixed widths of the monotone valley detector.
// No dependencies; imported by every module of the block.
`default_nettype none
package mvd_pkg;

    // Fixed field widths.
    localparam int WIN_BITS    = 11;
    localparam int SAMPLE_W    = 16;
    localparam int DAY_W       = 16;
    localparam logic [WIN_BITS-1:0] RUN_MAX = '1;

    // Per-request decision carried from the run tracker to the result stage.
    typedef struct packed {
        logic             hit;      // rising run long enough and window usable
        logic             w_zero;   // zero window: no ring lookup needed
        logic [DAY_W-1:0] day_index;
    } t_step_info;

endpackage
`default_nettype wire

// ----- hdl/mvd_flag_ring.sv -----
// Ring of one-bit falling-run flags, one synchronous memory port pair.
// Depends on mvd_pkg; read data is registered.
`default_nettype none
module mvd_flag_ring
    import mvd_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int AW         = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic          i_wr_data,
    output logic               o_rd_data
);

    logic r_mem [MAX_WINDOW];
    logic r_rd_data;

    // Read-before-write: a read of the entry written in the same cycle
    // returns the value stored one full ring turn earlier.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data            <= r_mem[i_rd_addr];
            r_mem[i_wr_addr]     <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- hdl/mvd_run_track.sv -----
// Run tracker: sample index, previous sample, saturating runs, ring pointer.
// Depends on mvd_pkg and the assertion header; drives the flag ring addresses.
`default_nettype none
`include "monotone_valley_detector_assert.svh"
module mvd_run_track
    import mvd_pkg::*;
#(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 16,
    parameter int AW          = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [WIN_BITS-1:0] i_cfg_wr_data,
    input  wire logic                i_accept,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_start,
    output t_step_info               o_info,
    output logic [AW-1:0]            o_rd_addr,
    output logic [AW-1:0]            o_wr_addr,
    output logic                     o_wr_data
);

    localparam int SB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CW = ((AW > WIN_BITS) ? AW : WIN_BITS) + 1;
    localparam int MW = 17;
    localparam logic [MW-1:0]  MAX_W   = MW'(MAX_WINDOW);
    localparam logic [CW-1:0]  RING_SZ = CW'(MAX_WINDOW);
    localparam logic [AW-1:0]  POS_TOP = AW'(MAX_WINDOW - 1);

    logic [WIN_BITS-1:0]   r_window;
    logic                  r_active;
    logic [INDEX_BITS-1:0] r_count;
    logic [SB-1:0]         r_prev;
    logic [WIN_BITS-1:0]   r_fall;
    logic [WIN_BITS-1:0]   r_rise;
    logic [AW-1:0]         r_pos;

    logic                  restart;
    logic [SB-1:0]         smp;
    logic [INDEX_BITS-1:0] idx;
    logic [WIN_BITS-1:0]   fall;
    logic [WIN_BITS-1:0]   rise;
    logic [AW-1:0]         pos;
    logic [AW-1:0]         pos_next;
    logic [CW-1:0]         pos_w;
    logic [CW-1:0]         win_w;
    logic [CW-1:0]         slot;
    logic [INDEX_BITS-1:0] diff;

    // Window register; write only while idle (the block does not enforce it).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (i_cfg_wr_en) begin
            r_window <= i_cfg_wr_data;
        end
    end

    // Runs and index for the incoming request.
    always_comb begin
        smp     = i_sample[SB-1:0];
        restart = i_start || !r_active;
        if (restart) begin
            idx  = '0;
            fall = '0;
            rise = '0;
            pos  = '0;
        end else begin
            idx  = r_count;
            pos  = r_pos;
            if (r_prev >= smp) begin
                fall = (r_fall == RUN_MAX) ? RUN_MAX : r_fall + 1'b1;
            end else begin
                fall = '0;
            end
            if (r_prev <= smp) begin
                rise = (r_rise == RUN_MAX) ? RUN_MAX : r_rise + 1'b1;
            end else begin
                rise = '0;
            end
        end
        pos_next = (pos == POS_TOP) ? '0 : pos + 1'b1;
    end

    // Ring slot W entries back, modulo the ring size.
    always_comb begin
        pos_w = CW'(pos);
        win_w = CW'(r_window);
        if (win_w <= pos_w) begin
            slot = pos_w - win_w;
        end else begin
            slot = pos_w + RING_SZ - win_w;
        end
    end

    // Decision fields for the result stage.
    always_comb begin
        diff             = idx - INDEX_BITS'(r_window);
        o_info.hit       = (MW'(r_window) <= MAX_W) && (rise >= r_window);
        o_info.w_zero    = (r_window == '0);
        o_info.day_index = DAY_W'(diff);
        o_rd_addr        = slot[AW-1:0];
        o_wr_addr        = pos;
        o_wr_data        = (fall >= r_window);
    end

    // Sequence state update per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_prev   <= '0;
            r_fall   <= '0;
            r_rise   <= '0;
            r_pos    <= '0;
        end else if (i_accept) begin
            r_active <= 1'b1;
            r_count  <= idx + 1'b1;
            r_prev   <= smp;
            r_fall   <= fall;
            r_rise   <= rise;
            r_pos    <= pos_next;
        end
    end

    `MVD_ASSERT_NXT(a_start_clears_runs, i_accept && i_start, r_fall == '0 && r_rise == '0)
    `MVD_ASSERT_IMP(a_pos_in_ring, 1'b1, r_pos <= POS_TOP)
    `MVD_ASSERT_NXT(a_idle_holds, !i_accept, $stable(r_count) && $stable(r_pos))

endmodule
`default_nettype wire

// ----- hdl/monotone_valley_detector.sv -----
// Monotone valley detector: streams samples, reports valley indexes.
// The slave stream carries one sample per request (tdata) and a start flag
// (tuser) that opens a new sequence at index 0. A sample is a valley when
// it has at least W non-increasing steps before it and W non-decreasing
// steps after it; W is the window register, written through i_cfg_wr_en
// and i_cfg_wr_data while the block is idle.
// Each report leaves W samples late: it is made when the sample W places
// later arrives, and reaches the master stream after that sample is
// accepted, through the lookup stage (flag ring read), then output register.
// Throughput is one sample per clock, unless a receiver stall blocks it;
// per sample the flag ring does one read and one write, and the runs update.
// A receiver stall holds the report in the output register; the block keeps
// taking samples until a second report meets the full output register.
// Reset (i_rst_n low, synchronous) clears the window, runs and index; the
// flag ring needs no clearing since each entry is written before it is read.
`default_nettype none
`include "monotone_valley_detector_assert.svh"
module monotone_valley_detector
    import mvd_pkg::*;
#(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [WIN_BITS-1:0] i_cfg_wr_data,  // window_length
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
    input  wire logic                s_axis_tuser,   // [0] start_req
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [DAY_W-1:0]         m_axis_tdata    // [15:0] day_index
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic            accept;
    t_step_info      info;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_data;
    logic            ring_flag;

    logic            r_s1_valid;
    t_step_info      r_s1;
    logic            r_out_valid;
    logic [DAY_W-1:0] r_out_data;
    logic            s1_emit;
    logic            s1_move;

    assign accept = s_axis_tvalid && s_axis_tready;

    mvd_run_track #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .AW          (AW)
    ) u_run_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_sample      (s_axis_tdata),
        .i_start       (s_axis_tuser),
        .o_info        (info),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    mvd_flag_ring #(
        .MAX_WINDOW (MAX_WINDOW),
        .AW         (AW)
    ) u_flag_ring (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (ring_flag)
    );

    // Result decision once the ring flag is back; stage moves unless blocked.
    always_comb begin
        s1_emit       = r_s1.hit && (r_s1.w_zero || ring_flag);
        s1_move       = !r_s1_valid || !s1_emit || !r_out_valid || m_axis_tready;
        s_axis_tready = s1_move;
    end

    // Lookup stage: holds the request while the ring data is outstanding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= info;
        end
    end

    // Output register toward the master stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_emit && s1_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_emit && s1_move) begin
            r_out_data <= r_s1.day_index;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `MVD_ASSERT_NXT(a_s1_stall_holds, r_s1_valid && !s1_move, r_s1_valid && $stable(r_s1))
    `MVD_ASSERT_NXT(a_accept_fills_s1, accept, r_s1_valid)
    `MVD_ASSERT_IMP(a_block_on_full, r_s1_valid && s1_emit && r_out_valid && !m_axis_tready,
                    !s_axis_tready)

endmodule
`default_nettype wire

// ----- tb/mvd_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the monotone valley detector: watches both streams and the window port.
// It tracks the runs and flag ring, queues expected valley indexes and compares each result.
// Depends on mvd_pkg for the field widths.
module mvd_checker
    import mvd_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [WIN_BITS-1:0] i_cfg_wr_data,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    input  wire logic [SAMPLE_W-1:0] i_s_tdata,
    input  wire logic                i_s_tuser,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    input  wire logic [DAY_W-1:0]    i_m_tdata,
    output int                       o_mismatches,
    output int                       o_pending
);

    localparam int RING_BITS = $clog2(RING_DEPTH);

    // Tracker state, kept apart from the block's own registers.
    logic [WIN_BITS-1:0]  window_len;
    logic [DAY_W-1:0]     next_day;
    logic [SAMPLE_W-1:0]  last_sample;
    logic [WIN_BITS-1:0]  fall_len;
    logic [WIN_BITS-1:0]  rise_len;
    logic [RING_DEPTH-1:0] fall_ok_ring;
    logic [RING_BITS-1:0] ring_wr_pos;
    bit                   in_sequence;

    logic [DAY_W-1:0] valley_days_q[$];
    int               mismatch_count;

    // Advances the tracker by one accepted sample and queues a valley index if one is due.
    task automatic track_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
        logic [DAY_W-1:0]     day;
        logic [WIN_BITS-1:0]  fall;
        logic [WIN_BITS-1:0]  rise;
        logic [RING_BITS-1:0] slot;
        bit                   flag;

        if (restart || !in_sequence) begin
            day         = '0;
            fall        = '0;
            rise        = '0;
            ring_wr_pos = '0;
            in_sequence = 1'b1;
        end else begin
            day  = next_day;
            fall = (last_sample >= value) ? ((fall_len == RUN_MAX) ? RUN_MAX : fall_len + 1'b1)
                                          : '0;
            rise = (last_sample <= value) ? ((rise_len == RUN_MAX) ? RUN_MAX : rise_len + 1'b1)
                                          : '0;
        end

        // A sample W places back is a valley once W rising steps follow it.
        if (window_len <= RING_DEPTH && rise >= window_len) begin
            if (window_len == 0) begin
                flag = 1'b1;
            end else begin
                slot = ring_wr_pos - window_len[RING_BITS-1:0];
                flag = fall_ok_ring[slot];
            end
            if (flag) begin
                valley_days_q.insert(valley_days_q.size(), day - window_len);
            end
        end

        fall_ok_ring[ring_wr_pos] = (fall >= window_len);
        ring_wr_pos = ring_wr_pos + 1'b1;
        next_day    = day + 1'b1;
        last_sample = value;
        fall_len    = fall;
        rise_len    = rise;
    endtask

    // Results are compared before the new request is tracked; a result never
    // leaves in the cycle its sample is taken.
    always @(posedge i_clk) begin
        logic [DAY_W-1:0] want;

        if (!i_rst_n) begin
            window_len     = '0;
            next_day       = '0;
            last_sample    = '0;
            fall_len       = '0;
            rise_len       = '0;
            fall_ok_ring   = '0;
            ring_wr_pos    = '0;
            in_sequence    = 1'b0;
            mismatch_count = 0;
            valley_days_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                window_len = i_cfg_wr_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (valley_days_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: day_index %0d with nothing pending",
                                 i_m_tdata);
                    end
                end else begin
                    want = valley_days_q.pop_front();
                    if (i_m_tdata !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("day_index mismatch: expected %0d, got %0d",
                                     want, i_m_tdata);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                track_sample(i_s_tdata, i_s_tuser);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= valley_days_q.size();
    end

endmodule

// ----- tb/tb_monotone_valley_detector.sv -----
`timescale 1ns / 100ps
// Top of the valley detector testbench: clock, reset, sample and result stream drivers.
// Depends on mvd_pkg, the monotone_valley_detector RTL and the mvd_checker scoreboard.
module tb_monotone_valley_detector;
    import mvd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;

    typedef enum int {SEG_FALL, SEG_RISE, SEG_FLAT, SEG_NOISE} t_segment;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [WIN_BITS-1:0] cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [DAY_W-1:0]    m_tdata;

    int mismatches;
    int pending;
    bit quiet;
    bit hold_request;
    bit hold_done;

    monotone_valley_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    mvd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offers one sample request, sometimes after an idle burst, and waits for its acceptance.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= restart;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Stops offering, drains all expected results, lets the pipeline settle, writes the window.
    task automatic set_window(input logic [WIN_BITS-1:0] width);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random falling, rising, flat and noise segments; lengths scale with the window up to 64.
    task automatic run_valley_phase(input int n_items, input int width, input bit allow_start);
        int       level;
        int       seg_left;
        int       max_len;
        int       max_step;
        t_segment kind;
        int       pick;
        logic     restart;

        level    = $urandom_range(0, 65535);
        seg_left = 0;
        max_len  = (width > 60) ? 64 : width + 3;
        max_step = 3;
        kind     = SEG_FLAT;
        for (int k = 0; k < n_items; k++) begin
            if (seg_left == 0) begin
                pick     = $urandom_range(0, 9);
                kind     = (pick < 4) ? SEG_FALL : (pick < 8) ? SEG_RISE :
                           (pick == 8) ? SEG_FLAT : SEG_NOISE;
                seg_left = $urandom_range(1, max_len);
                max_step = ($urandom_range(0, 3) == 0) ? 8000 : 3;
            end
            case (kind)
                SEG_FALL: begin
                    level = level - $urandom_range(0, max_step);
                    if (level < 0) level = 0;
                end
                SEG_RISE: begin
                    level = level + $urandom_range(0, max_step);
                    if (level > 65535) level = 65535;
                end
                SEG_NOISE: begin
                    level = $urandom_range(0, 65535);
                end
                default: begin
                end
            endcase
            seg_left--;
            restart = allow_start && ($urandom_range(0, 79) == 0);
            send_sample(level[SAMPLE_W-1:0], restart);
        end
    endtask

    // Result side: random stalls, one long hold on request, full rate when quiet.
    initial begin
        forever begin
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        int stall_cycles;

        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: directed cases, random phases over several windows, a ring wrap at full rate.
    initial begin
        logic [WIN_BITS-1:0] widths[12];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero window after reset: every sample is a valley; the first one needs no start.
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // Window of two: a clean valley, equal steps, then a flat sequence.
        set_window(11'd2);
        send_sample(16'd9, 1'b1);
        send_sample(16'd7, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd3, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd7, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd9, 1'b0);
        send_sample(16'd100, 1'b1);
        send_sample(16'd100, 1'b0);
        send_sample(16'd100, 1'b0);
        send_sample(16'd100, 1'b0);

        // Window above the ring size: nothing is reported.
        set_window(11'd2047);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);

        // Random phases; the zero window phase also carries the long receiver hold.
        widths = '{11'd1, 11'd3, 11'd2, 11'd0, 11'd5, 11'd1025,
                   11'd8, 11'd4, 11'd1, 11'd2047, 11'd6, 11'd2};
        foreach (widths[p]) begin
            set_window(widths[p]);
            if (widths[p] == 0) hold_request = 1'b1;
            run_valley_phase(50, int'(widths[p]), 1'b1);
        end

        // Last part at full rate: one sequence long enough to wrap the flag ring.
        set_window(11'd3);
        quiet = 1'b1;
        run_valley_phase(1100, 3, 1'b0);

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mvd_pkg.sv
hdl/mvd_flag_ring.sv
hdl/mvd_run_track.sv
hdl/monotone_valley_detector.sv
tb/mvd_checker.sv
tb/tb_monotone_valley_detector.sv
